/* hw/rtl/number_to_ascii_digits_top_defines.svh */
// ----------------------------------------------------------------------------
// number_to_ascii_digits_top_defines
// Assertion macros shared by the checker of the digit converter.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_DIGITS_TOP_DEFINES_SVH
`define NUMBER_TO_ASCII_DIGITS_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define NAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/nac_pkg.sv */
// ----------------------------------------------------------------------------
// nac_pkg
// Types and constants of the binary to ASCII digit converter.
// ----------------------------------------------------------------------------
package nac_pkg;

    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 7;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'hA;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/nac_dabble.sv */
// ----------------------------------------------------------------------------
// nac_dabble
// One shift-and-add-3 step over a packed BCD register.
// ----------------------------------------------------------------------------
module nac_dabble
    import nac_pkg::*;
#(
    parameter int unsigned NDIG = 10
) (
    input  logic [DIGIT_W*NDIG-1:0] i_bcd,
    input  logic                    i_bit,
    output logic [DIGIT_W*NDIG-1:0] o_bcd
);

    logic [DIGIT_W*NDIG-1:0] w_adj;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (i_bcd[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
                w_adj[DIGIT_W*i +: DIGIT_W] = i_bcd[DIGIT_W*i +: DIGIT_W] + 4'd3;
            end else begin
                w_adj[DIGIT_W*i +: DIGIT_W] = i_bcd[DIGIT_W*i +: DIGIT_W];
            end
        end
    end

    assign o_bcd = {w_adj[DIGIT_W*NDIG-2:0], i_bit};

endmodule

/* hw/rtl/number_to_ascii_digits_top.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_digits_top
// Binary to ASCII decimal or hexadecimal digit string converter.
//
// A request is taken when start is high and busy is low: i_operation selects
// decimal (0) or hexadecimal (1), i_value holds the unsigned number. The block
// then raises busy and returns the digits most significant first, leading
// zeros dropped, one per cycle on o_ascii_char with o_strobe high for one
// cycle each; o_last marks the final digit. Zero gives the single digit '0'.
// Decimal requests run a shift-and-add-3 unit once per input bit, hex
// requests skip it. Leading zero digits are then dropped at one per cycle
// and the digits emitted at one per cycle. NDEC is the number of decimal
// digit places. A new request may be issued the cycle after busy falls.
// The receiver cannot stall: every digit appears exactly once.
// Reset clears the sequencer and the strobe; no request is in flight after.
// ----------------------------------------------------------------------------
module number_to_ascii_digits_top
    import nac_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_operation,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_strobe,
    output logic [CHAR_W-1:0]      o_ascii_char,
    output logic                   o_last
);

    localparam int unsigned NDEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int unsigned NHEX  = (VALUE_WIDTH + 3) / 4;
    localparam int unsigned BUF_W = DIGIT_W * NDEC;
    localparam int unsigned CNT_W = $clog2(NDEC + 1);
    localparam int unsigned BIT_W = $clog2(VALUE_WIDTH + 1);
    localparam int unsigned HEX_SH = DIGIT_W * (NDEC - NHEX);

    t_state                 r_state, n_state;
    logic [BUF_W-1:0]       r_buf, n_buf;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BIT_W-1:0]       r_bits, n_bits;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_strobe, n_strobe;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    logic [BUF_W-1:0]       w_dab;
    logic [DIGIT_W-1:0]     w_top;
    logic                   w_one;

    nac_dabble #(
        .NDIG (NDEC)
    ) u_dabble (
        .i_bcd (r_buf),
        .i_bit (r_bin[VALUE_WIDTH-1]),
        .o_bcd (w_dab)
    );

    assign w_top = r_buf[BUF_W-1 -: DIGIT_W];
    assign w_one = (r_cnt == CNT_W'(1));

    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_bin    = r_bin;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation == OP_HEX) begin
                        n_buf   = BUF_W'(i_value) << HEX_SH;
                        n_cnt   = CNT_W'(NHEX);
                        n_state = S_SKIP;
                    end else begin
                        n_buf   = '0;
                        n_bin   = i_value;
                        n_bits  = BIT_W'(VALUE_WIDTH);
                        n_cnt   = CNT_W'(NDEC);
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_buf  = w_dab;
                n_bin  = r_bin << 1;
                n_bits = r_bits - BIT_W'(1);
                if (r_bits == BIT_W'(1)) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == '0 && !w_one) begin
                    n_buf = r_buf << DIGIT_W;
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_char   = digit_char(w_top);
                n_last   = w_one;
                n_buf    = r_buf << DIGIT_W;
                n_cnt    = r_cnt - CNT_W'(1);
                if (w_one) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_bin  <= n_bin;
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

endmodule

/* hw/rtl/nac_chk.sv */
// ----------------------------------------------------------------------------
// nac_chk
// Port-level checks of the digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "number_to_ascii_digits_top_defines.svh"

module nac_chk
    import nac_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic [CHAR_W-1:0] o_ascii_char,
    input logic              o_last
);

    `NAC_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request taken but busy not raised")
    `NAC_ASSERT_NOW(a_char_rng, o_strobe,
        (o_ascii_char >= 7'h30 && o_ascii_char <= 7'h39) ||
        (o_ascii_char >= 7'h41 && o_ascii_char <= 7'h46),
        "digit out of range")
    `NAC_ASSERT_NEXT(a_idle_quiet, !busy, !o_strobe, "digit strobed with no request in flight")
    `NAC_ASSERT_NEXT(a_last_gap, o_strobe && o_last, !o_strobe, "digit strobed after last")
    `NAC_ASSERT_NEXT(a_run_on, o_strobe && !o_last, o_strobe, "digit string broken before last")

endmodule

bind number_to_ascii_digits_top nac_chk u_nac_chk (.*);
